>>> design/cdnt_pkg.sv
// ----------------------------------------------------------------------------
// cdnt_pkg
// Types, constants and tables shared by the civil date to NTP converter.
// ----------------------------------------------------------------------------
package cdnt_pkg;

  // Request: one local calendar date and time, fields already split.
  typedef struct packed {
    logic [11:0] calendar_year;
    logic [3:0]  calendar_month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [9:0]  millisecond;
  } cdnt_req_t;

  // Response: 64-bit NTP timestamp.
  typedef struct packed {
    logic [31:0] ntp_seconds;
    logic [31:0] ntp_fraction;
  } cdnt_rsp_t;

  localparam int unsigned OffsetWidth = 17;
  localparam logic signed [OffsetWidth-1:0] OffsetReset = 17'sd21600;

  // Seconds from 1900-01-01 to 1970-01-01.
  localparam logic [31:0] EpochDelta = 32'd2208988800;
  localparam logic [31:0] SecondsPerDay = 32'd86400;

  // Leap years in [1, 1969].
  localparam logic [10:0] LeapsBefore1970 = 11'd477;

  // floor(x / 100) = (x * Recip100) >> Recip100Shift for x below 4096.
  localparam int unsigned Recip100Shift = 19;
  localparam logic [12:0] Recip100 = 13'd5243;

  // Fraction path: ms * 2^29 = 125 * (ms * FracScale) + ms * FracResid.
  localparam logic [22:0] FracScale = 23'd4294967;
  localparam logic [5:0]  FracResid = 6'd37;
  // floor(x / 125) = (x * Recip125) >> Recip125Shift for x below 2^16.
  localparam int unsigned Recip125Shift = 24;
  localparam logic [17:0] Recip125 = 18'd134218;
  // Round up when the remainder over 125 reaches this value.
  localparam logic [6:0]  FracRoundAt = 7'd63;

  // Days before the first of each month in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

>>> design/civil_date_to_ntp_timestamp.sv
// ----------------------------------------------------------------------------
// civil_date_to_ntp_timestamp
// Converts a local Gregorian date and time into a 64-bit NTP timestamp.
//
// Each request carries year, month, day, hour, minute, second and
// millisecond; each response carries NTP seconds since 1900 (wrapping modulo
// 2^32) and the fraction round(ms * 2^32 / 1000). The local-to-UTC offset in
// seconds is a signed 17-bit register (reset 21600) written through
// cfg_we_i / cfg_wdata_i; write it only while no request is in flight.
// The block is a five-stage pipeline that accepts one request per cycle
// while it is not held; an accepted request passes through the stages in
// order and shows as a valid response in the response register. The whole
// pipeline advances together; it holds only while the response register is
// full and out_stall_i is high, and in_stall_o shows exactly that. Field
// values are not range-checked: months above twelve act as December, a
// millisecond of 1000 or more carries into the seconds with a zero fraction.
// ----------------------------------------------------------------------------
module civil_date_to_ntp_timestamp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  cdnt_pkg::cdnt_req_t                    in_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output cdnt_pkg::cdnt_rsp_t                    out_rsp_o,
  input  logic                                   cfg_we_i,
  input  logic signed [cdnt_pkg::OffsetWidth-1:0] cfg_wdata_i
);
  import cdnt_pkg::*;

  // Pipeline control: one enable for all stages.
  logic       adv;
  logic [4:0] vld_q;

  logic signed [OffsetWidth-1:0] offset_q;

  // Stage 1: year terms, month table, time of day.
  logic signed [12:0] ydiff;
  logic [11:0]        ym1;
  logic [24:0]        p100m1, p100y;
  logic [22:0]        p400m1;
  logic signed [20:0] s1_y365_q, s1_y365_d;
  logic               s1_gt_q;
  logic [9:0]         s1_q4_q;
  logic [5:0]         s1_q100_q;
  logic [3:0]         s1_q400_q;
  logic [5:0]         s1_q100y_q;
  logic [11:0]        s1_year_q;
  logic               s1_late_q;
  logic [8:0]         s1_dbm_q;
  logic signed [5:0]  s1_dm1_q, s1_dm1_d;
  logic [16:0]        s1_tod_q, s1_tod_d;

  // Stage 2: leap-day counts and partial day sum.
  logic [10:0]        leaps_full;
  logic               leap;
  logic signed [20:0] s2_part_q, s2_part_d;
  logic [9:0]         s2_leaps_q, s2_leaps_d;
  logic               s2_extra_q;
  logic [16:0]        s2_tod_q;

  // Stage 3: days since 1970.
  logic signed [20:0] s3_days_q, s3_days_d;
  logic [16:0]        s3_tod_q;

  // Stage 4: day seconds and the sum of time of day, offset and epoch delta.
  logic [31:0]        s4_daysec_q, s4_daysec_d;
  logic [31:0]        s4_base_q, s4_base_d;

  // Stage 5: response register.
  logic [32:0]        frac33;
  cdnt_rsp_t          s5_rsp_q, s5_rsp_d;

  assign adv        = !(vld_q[4] && out_stall_i);
  assign in_stall_o = !adv;

  // ---- stage 1 ----
  assign ydiff     = $signed({1'b0, in_req_i.calendar_year}) - 13'sd1970;
  assign s1_y365_d = {{8{ydiff[12]}}, ydiff} * 21'sd365;
  assign ym1       = in_req_i.calendar_year - 12'd1;
  assign p100m1    = {13'd0, ym1} * {12'd0, Recip100};
  assign p400m1    = {13'd0, ym1[11:2]} * {10'd0, Recip100};
  assign p100y     = {13'd0, in_req_i.calendar_year} * {12'd0, Recip100};
  assign s1_dm1_d  = $signed({1'b0, in_req_i.day_of_month}) - 6'sd1;
  assign s1_tod_d  = {12'd0, in_req_i.hour_of_day} * 17'd3600
                   + {11'd0, in_req_i.minute_of_hour} * 17'd60
                   + {11'd0, in_req_i.second_of_minute};

  // ---- stage 2 ----
  // Leap years in [1970, year) = leaps_upto(year - 1) - leaps_upto(1969).
  assign leaps_full = {1'b0, s1_q4_q} - {5'd0, s1_q100_q} + {7'd0, s1_q400_q}
                    - LeapsBefore1970;
  assign s2_leaps_d = s1_gt_q ? leaps_full[9:0] : 10'd0;
  // Divisible by 4, and not a century unless the century count is too.
  assign leap = (s1_year_q[1:0] == 2'd0)
             && ((s1_year_q != 12'({6'd0, s1_q100y_q} * 12'd100))
              || (s1_q100y_q[1:0] == 2'd0));
  assign s2_part_d = s1_y365_q + $signed({12'd0, s1_dbm_q})
                   + {{15{s1_dm1_q[5]}}, s1_dm1_q};

  // ---- stage 3 ----
  assign s3_days_d = s2_part_q + $signed({11'd0, s2_leaps_q})
                   + $signed({20'd0, s2_extra_q});

  // ---- stage 4 ----
  assign s4_daysec_d = {{11{s3_days_q[20]}}, s3_days_q} * SecondsPerDay;
  assign s4_base_d   = {15'd0, s3_tod_q}
                     + {{(32-OffsetWidth){offset_q[OffsetWidth-1]}}, offset_q}
                     + EpochDelta;

  // ---- stage 5 ----
  // A fraction that reaches 2^32 carries into the seconds.
  always_comb begin
    s5_rsp_d.ntp_seconds  = s4_daysec_q + s4_base_q + {31'd0, frac33[32]};
    s5_rsp_d.ntp_fraction = frac33[32] ? 32'd0 : frac33[31:0];
  end

  cdnt_frac u_frac (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ms_i   (in_req_i.millisecond),
    .frac_o (frac33)
  );

  // Control state: valid bits and the offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      offset_q <= OffsetReset;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[3:0], in_valid_i};
      end
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  // Payload: advance with the pipeline, hold on stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_y365_q   <= s1_y365_d;
      s1_gt_q     <= in_req_i.calendar_year > 12'd1970;
      s1_q4_q     <= ym1[11:2];
      s1_q100_q   <= p100m1[Recip100Shift+5:Recip100Shift];
      s1_q400_q   <= p400m1[Recip100Shift+3:Recip100Shift];
      s1_q100y_q  <= p100y[Recip100Shift+5:Recip100Shift];
      s1_year_q   <= in_req_i.calendar_year;
      s1_late_q   <= in_req_i.calendar_month > 4'd2;
      s1_dbm_q    <= days_before(in_req_i.calendar_month);
      s1_dm1_q    <= s1_dm1_d;
      s1_tod_q    <= s1_tod_d;
      s2_part_q   <= s2_part_d;
      s2_leaps_q  <= s2_leaps_d;
      s2_extra_q  <= s1_late_q && leap;
      s2_tod_q    <= s1_tod_q;
      s3_days_q   <= s3_days_d;
      s3_tod_q    <= s2_tod_q;
      s4_daysec_q <= s4_daysec_d;
      s4_base_q   <= s4_base_d;
      s5_rsp_q    <= s5_rsp_d;
    end
  end

  assign out_valid_o = vld_q[4];
  assign out_rsp_o   = s5_rsp_q;

endmodule

>>> design/cdnt_frac.sv
// ----------------------------------------------------------------------------
// cdnt_frac
// Four-stage pipeline for round(ms * 2^32 / 1000), exact, 33-bit result.
// ----------------------------------------------------------------------------
module cdnt_frac (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [9:0]  ms_i,
  output logic [32:0] frac_o
);
  import cdnt_pkg::*;

  logic [32:0] r1_a0_q, r1_a0_d;
  logic [15:0] r1_x_q, r1_x_d;
  logic [32:0] r2_a0_q;
  logic [15:0] r2_x_q;
  logic [8:0]  r2_qt_q, r2_qt_d;
  logic [33:0] r2_prod;
  logic [32:0] r3_a_q, r3_a_d;
  logic [6:0]  r3_b_q, r3_b_d;
  logic [15:0] r3_qx;
  logic [32:0] r4_f_q, r4_f_d;

  // ms * 2^29 split into a multiple of 125 and a small residue
  assign r1_a0_d = {23'd0, ms_i} * {10'd0, FracScale};
  assign r1_x_d  = {6'd0, ms_i} * {10'd0, FracResid};

  // residue / 125 by reciprocal
  assign r2_prod = {18'd0, r1_x_q} * {16'd0, Recip125};
  assign r2_qt_d = r2_prod[Recip125Shift+8:Recip125Shift];

  assign r3_qx  = {7'd0, r2_qt_q} * 16'd125;
  assign r3_a_d = r2_a0_q + {24'd0, r2_qt_q};
  assign r3_b_d = 7'(r2_x_q - r3_qx);

  // round half up on the remainder
  assign r4_f_d = r3_a_q + {32'd0, (r3_b_q >= FracRoundAt)};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_a0_q <= r1_a0_d;
      r1_x_q  <= r1_x_d;
      r2_a0_q <= r1_a0_q;
      r2_x_q  <= r1_x_q;
      r2_qt_q <= r2_qt_d;
      r3_a_q  <= r3_a_d;
      r3_b_q  <= r3_b_d;
      r4_f_q  <= r4_f_d;
    end
  end

  assign frac_o = r4_f_q;

endmodule

>>> design/cdnt_check.sv
// ----------------------------------------------------------------------------
// cdnt_check
// Port-level checks for the civil date to NTP converter, bound to the top.
// ----------------------------------------------------------------------------
module cdnt_check (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input cdnt_pkg::cdnt_req_t                     in_req_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input cdnt_pkg::cdnt_rsp_t                     out_rsp_o,
  input logic                                    cfg_we_i,
  input logic signed [cdnt_pkg::OffsetWidth-1:0] cfg_wdata_i
);
  import cdnt_pkg::*;

  // The input side stalls only behind a held response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held response");

  // A request accepted with a free path later comes out as a valid response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("response missing after pipeline latency");

  // A held response keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("held response changed");

endmodule

bind civil_date_to_ntp_timestamp cdnt_check u_cdnt_check (.*);

>>> test/civil_date_to_ntp_timestamp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_date_to_ntp_timestamp_tb
// Self-checking bench for the civil date to NTP timestamp converter.
// Drives directed corner dates, then random dates under several local
// offsets and idle patterns. A scoreboard computes each timestamp from the
// request fields and compares it with the response.
// ----------------------------------------------------------------------------
module civil_date_to_ntp_timestamp_tb;
  import cdnt_pkg::*;

  localparam int ClkPeriod     = 2;
  localparam int ItemsPerPhase = 312;
  localparam int NumPhases     = 6;
  localparam int HoldOffCycles = 64;
  localparam int MaxPrinted    = 40;

  // Days before the first of each month; months past twelve act as December.
  localparam int DaysBeforeMonth [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212,
                                          243, 273, 304, 334, 334, 334, 334};

  // --------------------------------------------------------------------------
  // Scoreboard: predict the timestamp of each accepted request, then match
  // responses against the oldest prediction in order.
  // --------------------------------------------------------------------------
  class ntp_scoreboard;
    cdnt_rsp_t                      pending[$];
    logic signed [OffsetWidth-1:0]  offset;
    int                             errors;

    function new();
      offset = OffsetReset;
      errors = 0;
    endfunction

    // Leap years in [1, y] for y >= 1.
    function longint leaps_through(longint y);
      return y / 4 - y / 100 + y / 400;
    endfunction

    task report_mismatch(string msg);
      if (errors < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_request(cdnt_req_t r);
      longint     yr;
      longint     days;
      longint     total;
      bit         is_leap;
      logic [63:0] frac;
      cdnt_rsp_t  rsp;
      yr      = longint'(r.calendar_year);
      is_leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      // Years before 1970 count no leap days of the years between them and 1970.
      days = (yr - 1970) * 365;
      if (yr > 1970) days += leaps_through(yr - 1) - leaps_through(1969);
      days += DaysBeforeMonth[r.calendar_month];
      if (r.calendar_month > 4'd2 && is_leap) days += 1;
      // Day zero lands on the day before the first.
      days += longint'(r.day_of_month) - 1;
      total = days * 86400 + longint'(r.hour_of_day) * 3600
            + longint'(r.minute_of_hour) * 60 + longint'(r.second_of_minute)
            + longint'(offset) + 64'sd2208988800;
      rsp.ntp_seconds = total[31:0];
      // Exact rounding of ms * 2^32 / 1000.
      frac = ({22'b0, r.millisecond, 32'b0} + 64'd500) / 64'd1000;
      if (frac[63:32] != 0) begin
        // A millisecond of 1000 or more carries into the seconds.
        rsp.ntp_seconds  = rsp.ntp_seconds + 32'd1;
        rsp.ntp_fraction = '0;
      end else begin
        rsp.ntp_fraction = frac[31:0];
      end
      pending.push_back(rsp);
    endfunction

    task check_response(cdnt_rsp_t got);
      cdnt_rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("response %h with no request pending", got));
        return;
      end
      want = pending.pop_front();
      if (got.ntp_seconds !== want.ntp_seconds)
        report_mismatch($sformatf("ntp_seconds got %h want %h",
                                  got.ntp_seconds, want.ntp_seconds));
      if (got.ntp_fraction !== want.ntp_fraction)
        report_mismatch($sformatf("ntp_fraction got %h want %h",
                                  got.ntp_fraction, want.ntp_fraction));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  cdnt_req_t                     in_req    = '0;
  logic                          out_stall = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic signed [OffsetWidth-1:0] cfg_wdata = '0;
  logic                          in_stall;
  logic                          out_valid;
  cdnt_rsp_t                     out_rsp;

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 82;
  int          phase_idx     = -1;

  ntp_scoreboard sb = new();

  always #(ClkPeriod / 2) clk = ~clk;

  civil_date_to_ntp_timestamp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic cdnt_req_t make_req(int y, int mo, int d, int h, int mi,
                                         int s, int ms);
    cdnt_req_t r;
    r.calendar_year    = y[11:0];
    r.calendar_month   = mo[3:0];
    r.day_of_month     = d[4:0];
    r.hour_of_day      = h[4:0];
    r.minute_of_hour   = mi[5:0];
    r.second_of_minute = s[5:0];
    r.millisecond      = ms[9:0];
    return r;
  endfunction

  // Offer one request, idling first at the current rate. Keep valid high
  // into the next request unless an idle cycle is rolled.
  task automatic send_request(input cdnt_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Drain every outstanding request, then write the offset register.
  task automatic set_offset(input logic signed [OffsetWidth-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.offset = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at the current rate; at the start of the no-idle phase,
  // hold off for a long stretch so the pipeline fills and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_idx == 4 && !held) begin
        hold_left = HoldOffCycles;
        held      = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Check each accepted response against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_response(out_rsp);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cdnt_req_t                     r;
    logic signed [OffsetWidth-1:0] offs;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners at the reset offset.
    send_request(make_req(1970, 1, 1, 0, 0, 0, 0));
    send_request(make_req(2099, 12, 31, 23, 59, 59, 999));
    send_request(make_req(2000, 2, 29, 12, 0, 0, 500));
    send_request(make_req(2000, 3, 1, 0, 0, 0, 1));
    send_request(make_req(2100, 3, 1, 0, 0, 0, 0));
    send_request(make_req(2024, 2, 28, 23, 59, 59, 999));
    send_request(make_req(2024, 3, 1, 0, 0, 0, 0));
    send_request(make_req(2023, 3, 1, 0, 0, 0, 0));
    send_request(make_req(1969, 12, 31, 23, 59, 59, 0));
    send_request(make_req(1900, 3, 1, 0, 0, 0, 0));
    send_request(make_req(0, 3, 1, 0, 0, 0, 0));
    send_request(make_req(0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(4095, 15, 31, 31, 63, 63, 1023));
    send_request(make_req(2010, 0, 15, 6, 30, 0, 250));
    send_request(make_req(2010, 13, 15, 6, 30, 0, 250));
    send_request(make_req(2012, 15, 15, 6, 30, 0, 250));
    send_request(make_req(2015, 6, 0, 0, 0, 0, 0));
    send_request(make_req(2015, 6, 1, 0, 0, 0, 1000));
    send_request(make_req(2036, 2, 7, 0, 28, 15, 1000));
    send_request(make_req(2036, 2, 7, 0, 28, 16, 0));
    send_request(make_req(2050, 7, 4, 31, 63, 63, 999));
    send_request(make_req(2099, 1, 1, 0, 0, 0, 1));

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       offs = -17'sd50400;
        1:       offs = 17'sd50400;
        2:       offs = '0;
        3:       offs = -17'sd65536;
        4:       offs = 17'sd65535;
        default: offs = OffsetWidth'($signed($urandom_range(100800)) - 50400);
      endcase
      set_offset(offs);
      // Swap the idle pattern after two phases, then run flat out.
      if (ph < 2) begin
        send_idle_pct = 10;
        recv_idle_pct = 82;
      end else if (ph < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_idx = ph;
      repeat (ItemsPerPhase) begin
        if ($urandom_range(9) != 0) begin
          // Mostly valid calendar dates.
          r = make_req($urandom_range(2099, 1970), $urandom_range(12, 1),
                       $urandom_range(31, 1), $urandom_range(23),
                       $urandom_range(59), $urandom_range(59), $urandom_range(999));
        end else begin
          // Raw bits: out-of-range fields of every kind.
          r = cdnt_req_t'({16'($urandom), $urandom});
        end
        send_request(r);
      end
    end

    // Drain, then keep watching so that anything unexpected can still appear.
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
design/cdnt_pkg.sv
design/cdnt_frac.sv
design/civil_date_to_ntp_timestamp.sv
design/cdnt_check.sv
test/civil_date_to_ntp_timestamp_tb.sv
